[src/mpfp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfp_pkg
// Shared constants and helpers for the 2x2 matrix power block.
// ----------------------------------------------------------------------------
package mpfp_pkg;

  localparam int unsigned ENTRY_W   = 32;
  localparam int unsigned EXP_W     = 32;
  localparam int unsigned ONES_W    = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned STEP_W    = 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_BASE_00 = 2'd0;
  localparam cfg_idx_t REG_BASE_01 = 2'd1;
  localparam cfg_idx_t REG_BASE_10 = 2'd2;
  localparam cfg_idx_t REG_BASE_11 = 2'd3;

  // last step of one matrix product: eight multiplies plus one drain step
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

  function automatic logic [ONES_W-1:0] ones_count(input logic [ENTRY_W-1:0] v);
    logic [ONES_W-1:0] c;
    c = '0;
    for (int k = 0; k < ENTRY_W; k++) begin
      c = c + ONES_W'(v[k]);
    end
    return c;
  endfunction

endpackage

[src/matrix_power_fibonacci_popcount_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_power_fibonacci_popcount_top
// Raises the configured 2x2 base matrix to a 32-bit exponent by MSB-first
// square-and-multiply on one shared multiplier, and counts ones in entry 01.
// Each product runs on the single multiplier: eight multiply steps plus one
// drain step. busy is low in the strobe cycle, so the next word may start there.
// Reset: base matrix returns to {{1,1},{1,0}}; results cannot be stalled.
// ----------------------------------------------------------------------------
module matrix_power_fibonacci_popcount_top import mpfp_pkg::*; #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [EXP_W-1:0]     exponent_i,
  input  logic                 cfg_we_i,
  input  cfg_idx_t             cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                 valid_o,
  output logic [ENTRY_W-1:0]   entry_00_o,
  output logic [ENTRY_W-1:0]   entry_01_o,
  output logic [ENTRY_W-1:0]   entry_10_o,
  output logic [ENTRY_W-1:0]   entry_11_o,
  output logic [ONES_W-1:0]    ones_in_entry_01_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQR  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  typedef logic [WORD_WIDTH-1:0] word_t;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [EXP_W-1:0]  exp_q, exp_d;
  word_t             base_q [4];
  word_t             acc_q  [4];
  word_t             acc_d  [4];
  word_t             part_q [3];
  word_t             part_d [3];
  word_t             ymat   [4];
  word_t             sum_q, sum_d;
  word_t             prod_q, prod_d;
  word_t             mul_a, mul_b;
  word_t             add_res;
  logic              valid_q;
  logic [ENTRY_W-1:0] e00_q, e01_q, e10_q, e11_q;
  logic [ONES_W-1:0]  ones_q;

  // base registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q[0] <= WORD_WIDTH'(1);
      base_q[1] <= WORD_WIDTH'(1);
      base_q[2] <= WORD_WIDTH'(1);
      base_q[3] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE_00: base_q[0] <= WORD_WIDTH'(cfg_wdata_i);
        REG_BASE_01: base_q[1] <= WORD_WIDTH'(cfg_wdata_i);
        REG_BASE_10: base_q[2] <= WORD_WIDTH'(cfg_wdata_i);
        REG_BASE_11: base_q[3] <= WORD_WIDTH'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ymat[k] = (state_q == ST_SQR) ? acc_q[k] : base_q[k];
    end
  end

  // operand select: step s gives entry s>>1, inner index s[0]
  always_comb begin
    unique case (step_q)
      4'd0:    begin mul_a = acc_q[0]; mul_b = ymat[0]; end
      4'd1:    begin mul_a = acc_q[1]; mul_b = ymat[2]; end
      4'd2:    begin mul_a = acc_q[0]; mul_b = ymat[1]; end
      4'd3:    begin mul_a = acc_q[1]; mul_b = ymat[3]; end
      4'd4:    begin mul_a = acc_q[2]; mul_b = ymat[0]; end
      4'd5:    begin mul_a = acc_q[3]; mul_b = ymat[2]; end
      4'd6:    begin mul_a = acc_q[2]; mul_b = ymat[1]; end
      4'd7:    begin mul_a = acc_q[3]; mul_b = ymat[3]; end
      default: begin mul_a = '0;       mul_b = '0;       end
    endcase
  end

  assign prod_d  = WORD_WIDTH'(mul_a * mul_b);
  assign add_res = sum_q + prod_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    bit_d   = bit_q;
    exp_d   = exp_q;
    sum_d   = sum_q;
    part_d  = part_q;
    acc_d   = acc_q;

    unique case (step_q)
      4'd1, 4'd3, 4'd5, 4'd7: sum_d = prod_q;
      4'd2:                   part_d[0] = add_res;
      4'd4:                   part_d[1] = add_res;
      4'd6:                   part_d[2] = add_res;
      default: ;
    endcase

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d  = ST_SQR;
          step_d   = '0;
          bit_d    = BIT_W'(EXP_W - 1);
          exp_d    = exponent_i;
          acc_d[0] = WORD_WIDTH'(1);
          acc_d[1] = '0;
          acc_d[2] = '0;
          acc_d[3] = WORD_WIDTH'(1);
        end
      end
      ST_SQR, ST_MUL: begin
        if (step_q == STEP_LAST) begin
          acc_d[0] = part_q[0];
          acc_d[1] = part_q[1];
          acc_d[2] = part_q[2];
          acc_d[3] = add_res;
          step_d   = '0;
          if (state_q == ST_SQR && exp_q[bit_q]) begin
            state_d = ST_MUL;
          end else if (bit_q == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SQR;
            bit_d   = bit_q - 1'b1;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      bit_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      bit_q   <= bit_d;
      valid_q <= (state_q == ST_DONE);
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q  <= exp_d;
    sum_q  <= sum_d;
    prod_q <= prod_d;
    part_q <= part_d;
    acc_q  <= acc_d;
    if (state_q == ST_DONE) begin
      e00_q  <= ENTRY_W'(acc_q[0]);
      e01_q  <= ENTRY_W'(acc_q[1]);
      e10_q  <= ENTRY_W'(acc_q[2]);
      e11_q  <= ENTRY_W'(acc_q[3]);
      ones_q <= ones_count(ENTRY_W'(acc_q[1]));
    end
  end

  assign busy               = (state_q != ST_IDLE);
  assign valid_o            = valid_q;
  assign entry_00_o         = e00_q;
  assign entry_01_o         = e01_q;
  assign entry_10_o         = e10_q;
  assign entry_11_o         = e11_q;
  assign ones_in_entry_01_o = ones_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2x2 matrix power block. Exponent words go in
// through the start/busy handshake with random gaps, and the base matrix is
// rewritten between phases (reset base, zeros, all ones, random, Fibonacci).
// A local square-and-multiply predictor queues one expected matrix and
// popcount for every accepted word, and the monitor checks each strobed
// result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import mpfp_pkg::*;

  typedef logic [ENTRY_W-1:0] word_t;
  typedef struct packed {
    word_t m00;
    word_t m01;
    word_t m10;
    word_t m11;
  } mat2_t;
  typedef struct packed {
    mat2_t             mat;
    logic [ONES_W-1:0] ones;
  } power_word_t;

  localparam mat2_t IDENTITY  = '{32'd1, 32'd0, 32'd0, 32'd1};
  localparam mat2_t FIBONACCI = '{32'd1, 32'd1, 32'd1, 32'd0};

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  logic [EXP_W-1:0]  exponent_i  = '0;
  logic              cfg_we_i    = 1'b0;
  cfg_idx_t          cfg_idx_i   = REG_BASE_00;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              valid_o;
  word_t             entry_00_o;
  word_t             entry_01_o;
  word_t             entry_10_o;
  word_t             entry_11_o;
  logic [ONES_W-1:0] ones_in_entry_01_o;

  mat2_t            base_now = FIBONACCI;
  logic [EXP_W-1:0] exponent_queue[$];
  power_word_t      matrices_due[$];
  power_word_t      want;
  int unsigned      gap_left   = 0;
  int unsigned      calm_left  = 0;
  int               mismatches = 0;

  matrix_power_fibonacci_popcount_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .exponent_i         (exponent_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .valid_o            (valid_o),
    .entry_00_o         (entry_00_o),
    .entry_01_o         (entry_01_o),
    .entry_10_o         (entry_10_o),
    .entry_11_o         (entry_11_o),
    .ones_in_entry_01_o (ones_in_entry_01_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic mat2_t mat_mul(input mat2_t a, input mat2_t b);
    mat2_t r;
    r.m00 = a.m00 * b.m00 + a.m01 * b.m10;
    r.m01 = a.m00 * b.m01 + a.m01 * b.m11;
    r.m10 = a.m10 * b.m00 + a.m11 * b.m10;
    r.m11 = a.m10 * b.m01 + a.m11 * b.m11;
    return r;
  endfunction

  // MSB-first square-and-multiply, all arithmetic wraps at 32 bits
  function automatic power_word_t raise_base(input mat2_t b, input logic [EXP_W-1:0] n);
    power_word_t r;
    r.mat = IDENTITY;
    for (int k = EXP_W - 1; k >= 0; k--) begin
      r.mat = mat_mul(r.mat, r.mat);
      if (n[k]) begin
        r.mat = mat_mul(r.mat, b);
      end
    end
    r.ones = ONES_W'($countones(r.mat.m01));
    return r;
  endfunction

  function automatic void check_field(input string field, input word_t exp_v,
                                      input word_t got_v);
    if (got_v !== exp_v) begin
      $display("%0t %s mismatch: expected %h, got %h", $time, field, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // driver: gaps count down only while the block is idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      exponent_i <= '0;
      gap_left = 0;
    end else if (!(start && busy)) begin
      if (start) begin
        matrices_due.push_back(raise_base(base_now, exponent_i));
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 14);
          if ($urandom_range(0, 19) == 0) begin
            calm_left = $urandom_range(5, 40);
          end
        end
      end else if (gap_left > 0 && !busy) begin
        gap_left--;
      end
      if (gap_left == 0 && exponent_queue.size() > 0) begin
        start      <= 1'b1;
        exponent_i <= exponent_queue.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (matrices_due.size() == 0) begin
        $display("%0t unexpected word: expected none, got %h %h %h %h ones %0d", $time,
                 entry_00_o, entry_01_o, entry_10_o, entry_11_o, ones_in_entry_01_o);
        mismatches++;
      end else begin
        want = matrices_due.pop_front();
        check_field("entry_00", want.mat.m00, entry_00_o);
        check_field("entry_01", want.mat.m01, entry_01_o);
        check_field("entry_10", want.mat.m10, entry_10_o);
        check_field("entry_11", want.mat.m11, entry_11_o);
        check_field("ones_in_entry_01", word_t'(want.ones), word_t'(ones_in_entry_01_o));
      end
    end
  end

  task automatic wait_idle();
    while (exponent_queue.size() != 0 || matrices_due.size() != 0 || start) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input word_t val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_BASE_00: base_now.m00 = val;
      REG_BASE_01: base_now.m01 = val;
      REG_BASE_10: base_now.m10 = val;
      REG_BASE_11: base_now.m11 = val;
      default: ;
    endcase
  endtask

  task automatic set_base(input mat2_t m);
    wait_idle();
    write_reg(REG_BASE_11, m.m11);
    write_reg(REG_BASE_00, m.m00);
    write_reg(REG_BASE_10, m.m10);
    write_reg(REG_BASE_01, m.m01);
  endtask

  task automatic queue_random(input int unsigned count);
    logic [EXP_W-1:0] n;
    repeat (count) begin
      case ($urandom_range(0, 5))
        0: n = $urandom_range(0, 100);
        1: n = EXP_W'(1) << $urandom_range(0, EXP_W - 1);
        2: n = ~(EXP_W'(1) << $urandom_range(0, EXP_W - 1));
        3: n = $urandom() & $urandom();
        default: n = $urandom();
      endcase
      exponent_queue.push_back(n);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset base: Fibonacci, incl. the largest value that fits in 32 bits
    exponent_queue = '{32'd0, 32'd1, 32'd2, 32'd47, 32'd48, 32'hFFFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
    queue_random(200);

    set_base('{32'd0, 32'd0, 32'd0, 32'd0});
    exponent_queue = '{32'd0, 32'd7, 32'hFFFF_FFFF};
    queue_random(80);

    set_base('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    exponent_queue = '{32'd0, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'h8000_0000};
    queue_random(120);

    repeat (3) begin
      set_base('{$urandom(), $urandom(), $urandom(), $urandom()});
      queue_random(150);
    end

    set_base(FIBONACCI);
    queue_random(250);

    wait_idle();
    repeat (600) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
